[hw/rtl/utd_pkg.sv]
package utd_pkg;

    // pipeline depth: one stage per register rank, last stage is the output register
    localparam int N_STAGES = 5;

    typedef logic [N_STAGES-1:0] stage_en_t;

    // daylight rule codes
    typedef enum logic [2:0] {
        RULE_OFF = 3'd0,
        RULE_US  = 3'd1,
        RULE_EU  = 3'd2,
        RULE_AU  = 3'd3,
        RULE_NZ  = 3'd4
    } dst_rule_t;

    // daylight status codes
    localparam logic [2:0] ST_NO       = 3'd0;
    localparam logic [2:0] ST_YES      = 3'd1;
    localparam logic [2:0] ST_BEGINS   = 3'd2;
    localparam logic [2:0] ST_ENDS     = 3'd3;
    localparam logic [2:0] ST_BADMONTH = 3'd4;

    // configuration register indexes
    localparam logic CFG_TZ_OFFSET = 1'b0;
    localparam logic CFG_DST_RULE  = 1'b1;

    localparam logic signed [4:0] TZ_RESET = -5'sd8;

    // x/25 == (x*1311) >> 15 for x up to 1123
    localparam logic [10:0] RECIP_25 = 11'd1311;
    localparam int          RECIP_SH = 15;

    localparam logic [3:0] MON_MARCH     = 4'd3;
    localparam logic [3:0] MON_APRIL     = 4'd4;
    localparam logic [3:0] MON_SEPTEMBER = 4'd9;
    localparam logic [3:0] MON_OCTOBER   = 4'd10;
    localparam logic [3:0] MON_NOVEMBER  = 4'd11;
    localparam logic [3:0] MON_DECEMBER  = 4'd12;

    // per-month weekday shift for the Sunday calculation
    function automatic logic [2:0] mon_shift(input logic [3:0] mo);
        logic [2:0] r;
        case (mo)
            4'd1:    r = 3'd0;
            4'd2:    r = 3'd3;
            4'd3:    r = 3'd2;
            4'd4:    r = 3'd5;
            4'd5:    r = 3'd0;
            4'd6:    r = 3'd3;
            4'd7:    r = 3'd5;
            4'd8:    r = 3'd1;
            4'd9:    r = 3'd4;
            4'd10:   r = 3'd6;
            4'd11:   r = 3'd2;
            4'd12:   r = 3'd4;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

endpackage

[hw/rtl/utc_to_local_dst_time_top.sv]
// UTC to local time converter. Each input beat is the UTC time stamp of the current
// second; the output beat is the local time of the following second, with the
// standard offset (tz_offset, register 0) and the daylight rule (dst_rule, register 1:
// off, US, EU, AU, NZ) applied, plus the daylight status and the half-hour leap check
// flag. A beat can be taken every clock cycle unless back-pressure has filled the
// 5-stage pipeline whose longest step is the reciprocal multiply for the century terms
// of the weekday calculation. Each stage stalls only when it is full and the one after
// it is blocked, so a stalled output does not stop the input while bubbles remain.
// Write configuration only while the pipeline is empty.
module utc_to_local_dst_time_top
    import utd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [4:0]  cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [4:0] utc_hour, [10:5] utc_minute, [16:11] utc_second, [21:17] utc_day,
    // [25:22] utc_month, [37:26] utc_year, [39:38] zero
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [4:0] local_hour, [10:5] local_minute, [16:11] local_second,
    // [19:17] dst_status, [20] leap_check, [23:21] zero
    output logic [23:0] m_axis_tdata
);

    logic signed [4:0] tz_offset_reg;
    logic [2:0]        dst_rule_reg;

    logic [N_STAGES-1:0] valid_reg, valid_next;
    logic [N_STAGES:0]   ready;
    stage_en_t           en;

    logic [4:0]        hour_std;
    logic [5:0]        minute, second;
    logic              leap_mid;
    logic signed [6:0] day_adj;
    logic [3:0]        month;
    logic [2:0]        first_sun;
    logic [4:0]        last_sun;

    logic [4:0] local_hour;
    logic [5:0] local_minute, local_second;
    logic [2:0] dst_status;
    logic       leap_check;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tz_offset_reg <= TZ_RESET;
            dst_rule_reg  <= RULE_US;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TZ_OFFSET: tz_offset_reg <= $signed(cfg_data);
                CFG_DST_RULE:  dst_rule_reg  <= cfg_data[2:0];
                default:       ;
            endcase
        end
    end

    // stage k loads when it is empty or its contents move on
    always_comb
    begin
        ready[N_STAGES] = m_axis_tready;
        for (int k = N_STAGES - 1; k >= 0; k--)
            ready[k] = !valid_reg[k] || ready[k+1];
        for (int k = 0; k < N_STAGES; k++)
        begin
            if (k == 0)
                en[k] = ready[k] && s_axis_tvalid;
            else
                en[k] = ready[k] && valid_reg[k-1];
            valid_next[k] = ready[k] ? ((k == 0) ? s_axis_tvalid : valid_reg[k-1])
                                     : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign s_axis_tready = ready[0];
    assign m_axis_tvalid = valid_reg[N_STAGES-1];

    utd_clock u_clock (
        .clk        (clk),
        .en         (en),
        .tz         (tz_offset_reg),
        .utc_hour   (s_axis_tdata[4:0]),
        .utc_minute (s_axis_tdata[10:5]),
        .utc_second (s_axis_tdata[16:11]),
        .utc_day    (s_axis_tdata[21:17]),
        .hour_std   (hour_std),
        .minute     (minute),
        .second     (second),
        .leap_check (leap_mid),
        .day_adj    (day_adj)
    );

    utd_cal u_cal (
        .clk       (clk),
        .en        (en),
        .utc_month (s_axis_tdata[25:22]),
        .utc_year  (s_axis_tdata[37:26]),
        .month     (month),
        .first_sun (first_sun),
        .last_sun  (last_sun)
    );

    utd_dst u_dst (
        .clk          (clk),
        .en           (en[N_STAGES-1]),
        .rule         (dst_rule_reg),
        .hour_std     (hour_std),
        .minute       (minute),
        .second       (second),
        .leap_check   (leap_mid),
        .day_adj      (day_adj),
        .month        (month),
        .first_sun    (first_sun),
        .last_sun     (last_sun),
        .local_hour   (local_hour),
        .local_minute (local_minute),
        .local_second (local_second),
        .dst_status   (dst_status),
        .local_leap   (leap_check)
    );

    assign m_axis_tdata = {3'd0, leap_check, dst_status, local_second, local_minute, local_hour};

endmodule

[hw/rtl/utd_clock.sv]
module utd_clock
    import utd_pkg::*;
(
    input  logic               clk,
    input  stage_en_t          en,
    input  logic signed [4:0]  tz,
    input  logic [4:0]         utc_hour,
    input  logic [5:0]         utc_minute,
    input  logic [5:0]         utc_second,
    input  logic [4:0]         utc_day,
    output logic [4:0]         hour_std,
    output logic [5:0]         minute,
    output logic [5:0]         second,
    output logic               leap_check,
    output logic signed [6:0]  day_adj
);

    // stage 1
    logic signed [6:0] cur_sum;
    logic [6:0]        se_inc, mi_inc;
    logic [5:0]        hr_inc;
    logic              se_carry, mi_carry;
    logic signed [6:0] day_next;
    logic [5:0]        s1_se_reg, s1_mi_reg;
    logic [4:0]        s1_hr_reg;
    logic signed [6:0] s1_day_reg;

    // stage 2
    logic signed [6:0] std_sum;
    logic [4:0]        hr_std_next;
    logic [4:0]        s2_hr_reg, s3_hr_reg, s4_hr_reg;
    logic [5:0]        s2_mi_reg, s3_mi_reg, s4_mi_reg;
    logic [5:0]        s2_se_reg, s3_se_reg, s4_se_reg;
    logic              s2_leap_reg, s3_leap_reg, s4_leap_reg;
    logic signed [6:0] s2_day_reg, s3_day_reg, s4_day_reg;

    always_comb
    begin
        // local standard date follows the UTC hour of the current second
        cur_sum  = $signed({2'b00, utc_hour}) + 7'(tz);
        day_next = $signed({2'b00, utc_day});
        if (cur_sum < 0)
            day_next = day_next - 7'sd1;
        else if (cur_sum > 7'sd23)
            day_next = day_next + 7'sd1;

        se_inc   = {1'b0, utc_second} + 7'd1;
        se_carry = (se_inc >= 7'd60);
        mi_inc   = {1'b0, utc_minute} + {6'd0, se_carry};
        mi_carry = (mi_inc >= 7'd60);
        hr_inc   = {1'b0, utc_hour} + {5'd0, mi_carry};
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s1_se_reg  <= se_carry ? 6'd0 : se_inc[5:0];
            s1_mi_reg  <= mi_carry ? 6'd0 : mi_inc[5:0];
            s1_hr_reg  <= (hr_inc >= 6'd24) ? 5'd0 : hr_inc[4:0];
            s1_day_reg <= day_next;
        end
    end

    always_comb
    begin
        std_sum = $signed({2'b00, s1_hr_reg}) + 7'(tz);
        if (std_sum < 0)
            hr_std_next = 5'(std_sum + 7'sd24);
        else if (std_sum >= 7'sd24)
            hr_std_next = 5'(std_sum - 7'sd24);
        else
            hr_std_next = std_sum[4:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s2_hr_reg   <= hr_std_next;
            s2_mi_reg   <= s1_mi_reg;
            s2_se_reg   <= s1_se_reg;
            s2_leap_reg <= (s1_mi_reg == 6'd30) && (s1_se_reg == 6'd0);
            s2_day_reg  <= s1_day_reg;
        end
        if (en[2])
        begin
            s3_hr_reg   <= s2_hr_reg;
            s3_mi_reg   <= s2_mi_reg;
            s3_se_reg   <= s2_se_reg;
            s3_leap_reg <= s2_leap_reg;
            s3_day_reg  <= s2_day_reg;
        end
        if (en[3])
        begin
            s4_hr_reg   <= s3_hr_reg;
            s4_mi_reg   <= s3_mi_reg;
            s4_se_reg   <= s3_se_reg;
            s4_leap_reg <= s3_leap_reg;
            s4_day_reg  <= s3_day_reg;
        end
    end

    assign hour_std   = s4_hr_reg;
    assign minute     = s4_mi_reg;
    assign second     = s4_se_reg;
    assign leap_check = s4_leap_reg;
    assign day_adj    = s4_day_reg;

endmodule

[hw/rtl/utd_cal.sv]
module utd_cal
    import utd_pkg::*;
(
    input  logic        clk,
    input  stage_en_t   en,
    input  logic [3:0]  utc_month,
    input  logic [11:0] utc_year,
    output logic [3:0]  month,
    output logic [2:0]  first_sun,
    output logic [4:0]  last_sun
);

    logic [12:0] y_next;
    logic [12:0] s1_y_reg;
    logic [3:0]  s1_mo_reg;

    logic [21:0] p100;
    logic [19:0] p400;
    logic [12:0] s2_y_reg;
    logic [5:0]  s2_q100_reg;
    logic [3:0]  s2_q400_reg;
    logic [3:0]  s2_mo_reg;

    logic [13:0] day_sum;
    logic [12:0] s3_sum_reg;
    logic [3:0]  s3_mo_reg;

    logic [4:0]  fold1;
    logic [3:0]  fold2;
    logic [2:0]  dow;
    logic [2:0]  fd;
    logic [4:0]  ls31, ls30;
    logic [2:0]  s4_fd_reg;
    logic [4:0]  s4_ls_reg;
    logic [3:0]  s4_mo_reg;

    // stage 1: shifted year, January and February count with the year before
    assign y_next = 13'(utc_year) + 13'd400 - {12'd0, (utc_month < MON_MARCH)};

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s1_y_reg  <= y_next;
            s1_mo_reg <= utc_month;
        end
    end

    // stage 2: century terms by reciprocal multiply
    assign p100 = {11'd0, s1_y_reg[12:2]} * {11'd0, RECIP_25};
    assign p400 = {11'd0, s1_y_reg[12:4]} * {9'd0, RECIP_25};

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s2_y_reg    <= s1_y_reg;
            s2_q100_reg <= p100[RECIP_SH+5:RECIP_SH];
            s2_q400_reg <= p400[RECIP_SH+3:RECIP_SH];
            s2_mo_reg   <= s1_mo_reg;
        end
    end

    // stage 3: weekday sum
    assign day_sum = {1'b0, s2_y_reg} + {3'd0, s2_y_reg[12:2]} - {8'd0, s2_q100_reg}
                   + {10'd0, s2_q400_reg} + {11'd0, mon_shift(s2_mo_reg)} + 14'd1;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s3_sum_reg <= day_sum[12:0];
            s3_mo_reg  <= s2_mo_reg;
        end
    end

    // stage 4: mod 7 by folding octal digits (8 == 1 mod 7), then Sundays
    always_comb
    begin
        fold1 = {2'd0, s3_sum_reg[2:0]} + {2'd0, s3_sum_reg[5:3]} + {2'd0, s3_sum_reg[8:6]}
              + {2'd0, s3_sum_reg[11:9]} + {4'd0, s3_sum_reg[12]};
        fold2 = {1'b0, fold1[2:0]} + {2'd0, fold1[4:3]};
        dow   = (fold2 >= 4'd7) ? 3'(fold2 - 4'd7) : fold2[2:0];
        fd    = (dow == 3'd0) ? 3'd1 : 3'(4'd8 - {1'b0, dow});
        ls31  = (fd <= 3'd3) ? {2'd0, fd} + 5'd28 : {2'd0, fd} + 5'd21;
        ls30  = (fd <= 3'd2) ? {2'd0, fd} + 5'd28 : {2'd0, fd} + 5'd21;
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            s4_fd_reg <= fd;
            s4_ls_reg <= (s3_mo_reg == MON_SEPTEMBER) ? ls30 : ls31;
            s4_mo_reg <= s3_mo_reg;
        end
    end

    assign month     = s4_mo_reg;
    assign first_sun = s4_fd_reg;
    assign last_sun  = s4_ls_reg;

endmodule

[hw/rtl/utd_dst.sv]
module utd_dst
    import utd_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [2:0]        rule,
    input  logic [4:0]        hour_std,
    input  logic [5:0]        minute,
    input  logic [5:0]        second,
    input  logic              leap_check,
    input  logic signed [6:0] day_adj,
    input  logic [3:0]        month,
    input  logic [2:0]        first_sun,
    input  logic [4:0]        last_sun,
    output logic [4:0]        local_hour,
    output logic [5:0]        local_minute,
    output logic [5:0]        local_second,
    output logic [2:0]        dst_status,
    output logic              local_leap
);

    logic [2:0]        st;
    logic [4:0]        cd;
    logic              on_month;
    logic [2:0]        st_before, st_on, st_after;
    logic signed [6:0] cd_s;
    logic [4:0]        dec;
    logic              add;
    logic [5:0]        hr_sum;

    logic [4:0] hr_reg;
    logic [5:0] mi_reg, se_reg;
    logic [2:0] st_reg;
    logic       leap_reg;

    always_comb
    begin
        st        = ST_NO;
        on_month  = 1'b0;
        cd        = {2'd0, first_sun};
        st_before = ST_NO;
        st_on     = ST_BEGINS;
        st_after  = ST_YES;
        case (rule)
            RULE_US:
            begin
                if (month == MON_MARCH)
                begin
                    on_month = 1'b1;
                    cd       = {2'd0, first_sun} + 5'd7;
                end
                else if (month == MON_NOVEMBER)
                begin
                    on_month  = 1'b1;
                    st_before = ST_YES;
                    st_on     = ST_ENDS;
                    st_after  = ST_NO;
                end
                else if (month > MON_MARCH && month < MON_NOVEMBER)
                    st = ST_YES;
            end
            RULE_EU:
            begin
                cd = last_sun;
                if (month == MON_MARCH)
                    on_month = 1'b1;
                else if (month == MON_OCTOBER)
                begin
                    on_month  = 1'b1;
                    st_before = ST_YES;
                    st_on     = ST_ENDS;
                    st_after  = ST_NO;
                end
                else if (month > MON_MARCH && month < MON_OCTOBER)
                    st = ST_YES;
            end
            RULE_AU, RULE_NZ:
            begin
                if (month == MON_APRIL)
                begin
                    on_month  = 1'b1;
                    st_before = ST_YES;
                    st_on     = ST_ENDS;
                    st_after  = ST_NO;
                end
                else if (rule == RULE_AU && month == MON_OCTOBER)
                    on_month = 1'b1;
                else if (rule == RULE_NZ && month == MON_SEPTEMBER)
                begin
                    on_month = 1'b1;
                    cd       = last_sun;
                end
                else if (month < MON_APRIL)
                    st = ST_YES;
                else if (rule == RULE_AU && month > MON_OCTOBER)
                    st = ST_YES;
                else if (rule == RULE_NZ && month > MON_SEPTEMBER)
                    st = ST_YES;
            end
            default:
            begin
                st = ST_NO;
            end
        endcase

        cd_s = $signed({2'b00, cd});
        if (on_month)
        begin
            if (day_adj < cd_s)
                st = st_before;
            else if (day_adj == cd_s)
                st = st_on;
            else
                st = st_after;
        end

        // month check comes after the rule-off check
        if ((rule == RULE_US || rule == RULE_EU || rule == RULE_AU || rule == RULE_NZ)
            && (month == 4'd0 || month > MON_DECEMBER))
            st = ST_BADMONTH;

        // change hour: 01:00 EU, 02:00 elsewhere
        dec = (rule == RULE_EU) ? 5'd1 : 5'd2;
        case (st)
            ST_YES:    add = 1'b1;
            ST_BEGINS: add = (hour_std >= dec);
            ST_ENDS:   add = !(hour_std >= dec - 5'd1);
            default:   add = 1'b0;
        endcase

        hr_sum = {1'b0, hour_std} + {5'd0, add};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hr_reg   <= (hr_sum >= 6'd24) ? 5'(hr_sum - 6'd24) : hr_sum[4:0];
            mi_reg   <= minute;
            se_reg   <= second;
            st_reg   <= st;
            leap_reg <= leap_check;
        end
    end

    assign local_hour   = hr_reg;
    assign local_minute = mi_reg;
    assign local_second = se_reg;
    assign dst_status   = st_reg;
    assign local_leap   = leap_reg;

endmodule

[tb/utc_to_local_dst_time_top_tb.sv]
module utc_to_local_dst_time_top_tb
    import utd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTINGS_N = 10;
    localparam int STAMPS_PER_SETTING = 64;
    // rule codes past NZ carry no name in the package and act as off
    localparam int RULE_SPARE_LO = 5;
    localparam int RULE_SPARE_HI = 7;

    localparam int ZONE_TZ[SETTINGS_N] = '{0, 12, -12, -16, 15, 1, 10, -5, 9, -3};
    localparam int ZONE_RULE[SETTINGS_N] = '{RULE_EU, RULE_AU, RULE_NZ, RULE_SPARE_HI,
        RULE_OFF, RULE_EU, RULE_NZ, RULE_US, RULE_AU, RULE_SPARE_LO};

    // packed lowest field last so that hour lands in bits [4:0]
    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
    } stamp_t;

    typedef struct packed {
        logic        leap;
        logic [2:0]  status;
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
    } local_time_t;

    class time_scoreboard;
        logic signed [4:0] tz;
        logic [2:0]        rule;
        int                mon_skew[12];
        local_time_t       due_q[$];
        int                errors;
        int                checked;

        function new();
            tz = TZ_RESET;
            rule = RULE_US;
            mon_skew = '{0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};
            errors = 0;
            checked = 0;
        endfunction

        function void write_reg(logic idx, logic [4:0] v);
            if (idx == CFG_TZ_OFFSET)
                tz = v;
            else
                rule = v[2:0];
        endfunction

        function int pending();
            return due_q.size();
        endfunction

        // day of month of the first Sunday, month 1..12
        function int first_sun_day(int unsigned mo, int unsigned yr);
            int unsigned y;
            int unsigned dow;
            y = yr + 400 - ((mo < 3) ? 1 : 0);
            dow = (y + y / 4 - y / 100 + y / 400 + mon_skew[mo - 1] + 1) % 7;
            return (dow == 0) ? 1 : 8 - dow;
        endfunction

        function int last_sunday(int unsigned mo, int unsigned yr, int mdays);
            int f;
            f = first_sun_day(mo, yr);
            return f + 7 * ((mdays - f) / 7);
        endfunction

        function logic [2:0] by_change_day(int d, int cd, logic [2:0] lo, logic [2:0] on,
                                           logic [2:0] hi);
            if (d < cd)
                return lo;
            if (d == cd)
                return on;
            return hi;
        endfunction

        function void note_stamp(stamp_t s);
            int          hr;
            int          mi;
            int          se;
            int          day;
            int          tzv;
            int          dec;
            int          add;
            int unsigned mo;
            int unsigned yr;
            logic [2:0]  st;
            local_time_t r;
            hr = s.hour;
            mi = s.minute;
            se = s.second;
            day = s.day;
            mo = s.month;
            yr = s.year;
            tzv = tz;

            // local standard date decides the daylight state
            if (hr + tzv < 0)
                day--;
            if (hr + tzv > 23)
                day++;

            st = ST_NO;
            if (rule >= RULE_US && rule <= RULE_NZ)
            begin
                if (mo < 1 || mo > 12)
                    st = ST_BADMONTH;
                else if (rule == RULE_US)
                begin
                    if (mo == MON_MARCH)
                        st = by_change_day(day, first_sun_day(mo, yr) + 7, ST_NO, ST_BEGINS,
                                           ST_YES);
                    else if (mo == MON_NOVEMBER)
                        st = by_change_day(day, first_sun_day(mo, yr), ST_YES, ST_ENDS,
                                           ST_NO);
                    else if (mo > MON_MARCH && mo < MON_NOVEMBER)
                        st = ST_YES;
                end
                else if (rule == RULE_EU)
                begin
                    if (mo == MON_MARCH)
                        st = by_change_day(day, last_sunday(mo, yr, 31), ST_NO, ST_BEGINS,
                                           ST_YES);
                    else if (mo == MON_OCTOBER)
                        st = by_change_day(day, last_sunday(mo, yr, 31), ST_YES, ST_ENDS,
                                           ST_NO);
                    else if (mo > MON_MARCH && mo < MON_OCTOBER)
                        st = ST_YES;
                end
                else if (rule == RULE_AU)
                begin
                    if (mo == MON_APRIL)
                        st = by_change_day(day, first_sun_day(mo, yr), ST_YES, ST_ENDS,
                                           ST_NO);
                    else if (mo == MON_OCTOBER)
                        st = by_change_day(day, first_sun_day(mo, yr), ST_NO, ST_BEGINS,
                                           ST_YES);
                    else if (mo < MON_APRIL || mo > MON_OCTOBER)
                        st = ST_YES;
                end
                else
                begin
                    if (mo == MON_APRIL)
                        st = by_change_day(day, first_sun_day(mo, yr), ST_YES, ST_ENDS,
                                           ST_NO);
                    else if (mo == MON_SEPTEMBER)
                        st = by_change_day(day, last_sunday(mo, yr, 30), ST_NO, ST_BEGINS,
                                           ST_YES);
                    else if (mo < MON_APRIL || mo > MON_SEPTEMBER)
                        st = ST_YES;
                end
            end

            se++;
            if (se >= 60)
            begin
                se = 0;
                mi++;
            end
            if (mi >= 60)
            begin
                mi = 0;
                hr++;
            end
            if (hr >= 24)
                hr = 0;
            hr = ((hr + tzv) % 24 + 24) % 24;

            dec = (rule == RULE_EU) ? 1 : 2;
            add = 0;
            if (st == ST_YES)
                add = 1;
            else if (st == ST_BEGINS)
                add = (hr >= dec) ? 1 : 0;
            else if (st == ST_ENDS)
                add = (hr >= dec - 1) ? 0 : 1;
            hr += add;
            if (hr >= 24)
                hr -= 24;

            r.hour = hr[4:0];
            r.minute = mi[5:0];
            r.second = se[5:0];
            r.status = st;
            r.leap = (mi == 30 && se == 0);
            due_q.push_back(r);
        endfunction

        function void fail(string msg);
            errors++;
            if (errors <= 10)
                $display("%t: %s", $realtime, msg);
        endfunction

        function void check_beat(logic [23:0] d);
            local_time_t got;
            local_time_t exp_t;
            got = d[20:0];
            checked++;
            if (due_q.size() == 0)
            begin
                fail($sformatf("unexpected beat h=%0d m=%0d s=%0d st=%0d lc=%0d",
                     got.hour, got.minute, got.second, got.status, got.leap));
                return;
            end
            exp_t = due_q.pop_front();
            if (got.hour !== exp_t.hour || got.minute !== exp_t.minute ||
                got.second !== exp_t.second || got.status !== exp_t.status ||
                got.leap !== exp_t.leap)
                fail($sformatf({"mismatch: expected h=%0d m=%0d s=%0d st=%0d lc=%0d, ",
                     "got h=%0d m=%0d s=%0d st=%0d lc=%0d"},
                     exp_t.hour, exp_t.minute, exp_t.second, exp_t.status, exp_t.leap,
                     got.hour, got.minute, got.second, got.status, got.leap));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [4:0]  cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;

    time_scoreboard sb = new();
    int             cur_tz = TZ_RESET;
    int             burst_left = 0;
    int             stamps_sent = 0;
    int             cycles = 0;

    utc_to_local_dst_time_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timed out after %0d cycles", cycles);
        $display("status: fail");
        $finish;
    end

    // receiver: tready switches among randomly picked stall styles
    initial
    begin
        int mode;
        int left;
        int phase_cnt;
        mode = 0;
        left = 0;
        phase_cnt = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (left == 0)
            begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(20, 120);
            end
            left--;
            phase_cnt++;
            case (mode)
                0: m_axis_tready = 1'b1;
                1: m_axis_tready = 1'($urandom_range(0, 1));
                2: m_axis_tready = (phase_cnt % 4 == 0);
                default: m_axis_tready = ($urandom_range(0, 9) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_beat(m_axis_tdata);
    end

    function automatic stamp_t stamp(int h, int m, int s, int d, int mo, int y);
        stamp_t t;
        t.hour = 5'(h);
        t.minute = 6'(m);
        t.second = 6'(s);
        t.day = 5'(d);
        t.month = 4'(mo);
        t.year = 12'(y);
        return t;
    endfunction

    // mostly valid stamps steered at change days, decision hours and carries
    function automatic stamp_t random_stamp(int tzv);
        logic [63:0] raw;
        stamp_t      t;
        logic [3:0]  change_mon[5];
        int          k;
        change_mon = '{MON_MARCH, MON_APRIL, MON_SEPTEMBER, MON_OCTOBER, MON_NOVEMBER};
        k = $urandom_range(0, 99);
        if (k < 8)
        begin
            raw = {$urandom, $urandom};
            return raw[37:0];
        end
        t.year = ($urandom_range(0, 99) < 85) ? 12'($urandom_range(2000, 2199))
                                               : 12'($urandom_range(0, 4095));
        if ($urandom_range(0, 1) == 1)
            t.month = change_mon[$urandom_range(0, 4)];
        else
            t.month = 4'($urandom_range(1, 12));
        k = $urandom_range(0, 2);
        if (k == 0)
            t.day = 5'($urandom_range(1, 14));
        else if (k == 1)
            t.day = 5'($urandom_range(22, 31));
        else
            t.day = 5'($urandom_range(1, 31));
        if ($urandom_range(0, 99) < 35)
            t.hour = 5'(((int'($urandom_range(0, 3)) - tzv) % 24 + 24) % 24);
        else
            t.hour = 5'($urandom_range(0, 23));
        k = $urandom_range(0, 99);
        t.minute = (k < 25) ? 6'd59 : (k < 35) ? 6'd29 : 6'($urandom_range(0, 59));
        k = $urandom_range(0, 99);
        t.second = (k < 25) ? 6'd59 : (k < 35) ? 6'd60 : 6'($urandom_range(0, 60));
        return t;
    endfunction

    task automatic send_stamp(stamp_t s);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 30);
            if (gap > 0)
            begin
                @(negedge clk);
                s_axis_tvalid = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata = {2'b00, s};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_stamp(s);
        stamps_sent++;
    endtask

    task automatic set_zone(int tzv, int rule_v);
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = CFG_TZ_OFFSET;
        cfg_data = 5'(tzv);
        @(posedge clk);
        sb.write_reg(CFG_TZ_OFFSET, cfg_data);
        @(negedge clk);
        cfg_index = CFG_DST_RULE;
        // upper data bits are ignored by the rule register
        cfg_data = {2'($urandom_range(0, 3)), 3'(rule_v)};
        @(posedge clk);
        sb.write_reg(CFG_DST_RULE, cfg_data);
        @(negedge clk);
        cfg_we = 1'b0;
        cur_tz = tzv;
        burst_left = 0;
    endtask

    initial
    begin
        stamp_t directed[$];
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_TZ_OFFSET;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset zone is UTC-8 with the US rule; 2024 changes on 10 Mar and 3 Nov
        directed.push_back(stamp(0, 0, 0, 1, 1, 2000));
        directed.push_back(stamp(23, 59, 59, 31, 12, 2199));
        directed.push_back(stamp(23, 59, 60, 30, 6, 2016));
        directed.push_back(stamp(12, 29, 59, 15, 7, 2100));
        directed.push_back(stamp(8, 59, 59, 10, 3, 2024));
        directed.push_back(stamp(9, 59, 59, 10, 3, 2024));
        directed.push_back(stamp(8, 59, 59, 3, 11, 2024));
        directed.push_back(stamp(7, 59, 59, 3, 11, 2024));
        directed.push_back(stamp(9, 59, 59, 3, 11, 2024));
        directed.push_back(stamp(3, 0, 0, 11, 3, 2024));
        directed.push_back(stamp(0, 0, 0, 1, 3, 2024));
        directed.push_back(stamp(5, 10, 20, 14, 0, 2050));
        directed.push_back(stamp(5, 10, 20, 14, 13, 2050));
        directed.push_back(stamp(31, 63, 63, 31, 15, 4095));
        directed.push_back(stamp(10, 0, 0, 8, 3, 0));
        directed.push_back(stamp(24, 30, 5, 5, 5, 2030));
        directed.push_back(stamp(1, 60, 10, 4, 4, 2030));
        directed.push_back(stamp(2, 0, 61, 20, 8, 2040));
        directed.push_back(stamp(4, 59, 59, 1, 1, 2001));
        directed.push_back(stamp(0, 0, 0, 0, 0, 0));
        directed.push_back(stamp(10, 29, 59, 20, 11, 2150));
        directed.push_back(stamp(17, 30, 0, 31, 10, 2199));
        foreach (directed[i])
            send_stamp(directed[i]);

        for (int p = 0; p <= SETTINGS_N; p++)
        begin
            if (p > 0)
                set_zone(ZONE_TZ[p - 1], ZONE_RULE[p - 1]);
            repeat (STAMPS_PER_SETTING) send_stamp(random_stamp(cur_tz));
        end

        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (N_STAGES + 4) @(posedge clk);

        $display("%0d UTC stamps converted over %0d zone/rule settings, %0d beats checked",
                 stamps_sent, SETTINGS_N + 1, sb.checked);
        $display("%0d errors in %0d cycles", sb.errors, cycles);
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
